@@ hdl/hhfp_pkg.sv @@
`default_nettype none

package hhfp_pkg;

    localparam int LEN_BITS = 32;
    localparam int CL_BITS  = 32;
    localparam int NAME_LEN = 15;

    localparam logic [2:0] KIND_METHOD   = 3'd0;
    localparam logic [2:0] KIND_PATH     = 3'd1;
    localparam logic [2:0] KIND_QUERY    = 3'd2;
    localparam logic [2:0] KIND_PAYLOAD  = 3'd3;
    localparam logic [2:0] KIND_HDR_DONE = 3'd4;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef struct packed {
        logic                valid;
        logic [2:0]          kind;
        logic [7:0]          out_byte;
        logic [CL_BITS-1:0]  body_len;
        logic                last_payload;
    } hhfp_result_t;

    function automatic logic [7:0] key_char(input logic [3:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = "C";
            4'd1:    ch = "o";
            4'd2:    ch = "n";
            4'd3:    ch = "t";
            4'd4:    ch = "e";
            4'd5:    ch = "n";
            4'd6:    ch = "t";
            4'd7:    ch = "-";
            4'd8:    ch = "L";
            4'd9:    ch = "e";
            4'd10:   ch = "n";
            4'd11:   ch = "g";
            4'd12:   ch = "t";
            4'd13:   ch = "h";
            4'd14:   ch = ":";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [CL_BITS-1:0] to_cl(input logic [LEN_BITS-1:0] len);
        logic [LEN_BITS+CL_BITS-1:0] wide;
        wide = {{CL_BITS{1'b0}}, len};
        return wide[CL_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

@@ hdl/hhfp_if.sv @@
`default_nettype none

interface hhfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       msg_start;

    modport source (output valid, output in_byte, output msg_start, input ready);
    modport sink   (input valid, input in_byte, input msg_start, output ready);
endinterface

interface hhfp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  out_byte;
    logic [31:0] body_len;
    logic        last_payload;

    modport source (output valid, output kind, output out_byte, output body_len,
                    output last_payload, input ready);
    modport sink   (input valid, input kind, input out_byte, input body_len,
                    input last_payload, output ready);
endinterface

interface hhfp_cfg_if;
    logic valid;
    logic ready;
    logic parse_mode;

    modport source (output valid, output parse_mode, input ready);
    modport sink   (input valid, input parse_mode, output ready);
endinterface

`default_nettype wire

@@ hdl/http_header_field_parser_unit.sv @@
// HTTP header field parser.
// msg channel: one message byte per transaction, with msg_start marking the
// first byte of a new message (which restarts the parse).
// res channel: at most one result transaction per input byte: method, path,
// query/status or payload bytes, and one headers-done marker carrying the
// parsed Content-Length. Bytes that yield nothing are absorbed silently.
// cfg channel: parse_mode, 0 = request line, 1 = status line; always ready.
// A byte is taken into the input register, parsed from there, and its result
// is captured in the result register that drives res; one byte per cycle
// while res does not stall, limited by the single parse-state update per byte.
// Reset (rst_n low, asynchronous) clears the parse state, parse_mode and the
// valid bits of both pipeline registers; no result is pending after reset.
// When res stalls, the result register holds, an empty input register still
// takes one more byte, and then msg.ready drops until res moves.
`default_nettype none

module http_header_field_parser_unit
    import hhfp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    hhfp_in_if.sink    msg,
    hhfp_out_if.source res,
    hhfp_cfg_if.sink   cfg
);

    logic         mode_reg;
    logic         a_valid_reg;
    logic [7:0]   a_byte_reg;
    logic         a_start_reg;
    logic         r_valid_reg;
    hhfp_result_t r_data_reg;
    hhfp_result_t core_res;
    logic         advance;

    assign advance   = !r_valid_reg || res.ready;
    assign msg.ready = !a_valid_reg || advance;
    assign cfg.ready = 1'b1;

    hhfp_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (a_valid_reg && advance),
        .in_byte    (a_byte_reg),
        .msg_start  (a_start_reg),
        .parse_mode (mode_reg),
        .result     (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 1'b0;
            a_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                mode_reg <= cfg.parse_mode;
            end
            if (msg.ready)
            begin
                a_valid_reg <= msg.valid;
            end
            if (advance)
            begin
                r_valid_reg <= a_valid_reg && core_res.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (msg.ready && msg.valid)
        begin
            a_byte_reg  <= msg.in_byte;
            a_start_reg <= msg.msg_start;
        end
        if (advance && a_valid_reg && core_res.valid)
        begin
            r_data_reg <= core_res;
        end
    end

    assign res.valid          = r_valid_reg;
    assign res.kind           = r_data_reg.kind;
    assign res.out_byte       = r_data_reg.out_byte;
    assign res.body_len       = r_data_reg.body_len;
    assign res.last_payload   = r_data_reg.last_payload;

endmodule

`default_nettype wire

@@ hdl/hhfp_parse.sv @@
`default_nettype none

module hhfp_parse
    import hhfp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step,
    input  wire logic [7:0]   in_byte,
    input  wire logic         msg_start,
    input  wire logic         parse_mode,
    output hhfp_result_t      result
);

    localparam logic [3:0] ST_FIRST   = 4'd0;
    localparam logic [3:0] ST_PATH    = 4'd1;
    localparam logic [3:0] ST_SKIPQ   = 4'd2;
    localparam logic [3:0] ST_QVAL    = 4'd3;
    localparam logic [3:0] ST_EOL     = 4'd4;
    localparam logic [3:0] ST_NAME    = 4'd5;
    localparam logic [3:0] ST_VALUE   = 4'd6;
    localparam logic [3:0] ST_LINEEND = 4'd7;
    localparam logic [3:0] ST_STATUS  = 4'd8;
    localparam logic [3:0] ST_HDRCR   = 4'd9;
    localparam logic [3:0] ST_PAYLOAD = 4'd10;
    localparam logic [3:0] ST_STOP    = 4'd11;

    logic [3:0]          stage_reg, stage_next, stage_cur;
    logic [4:0]          pos_reg, pos_next, pos_cur;
    logic                match_reg, match_next, match_cur;
    logic [LEN_BITS-1:0] accum_reg, accum_next, accum_cur;
    logic [1:0]          done_reg, done_next, done_cur;
    logic [LEN_BITS-1:0] len_reg, len_next, len_cur;
    logic [LEN_BITS-1:0] left_reg, left_next, left_cur;

    logic                is_digit;
    logic                is_blank;
    logic [LEN_BITS-1:0] digit_val;
    logic [LEN_BITS-1:0] accum_x10;

    always_comb
    begin
        stage_cur = msg_start ? ST_FIRST : stage_reg;
        pos_cur   = msg_start ? 5'd0 : pos_reg;
        match_cur = msg_start ? 1'b1 : match_reg;
        accum_cur = msg_start ? '0 : accum_reg;
        done_cur  = msg_start ? 2'd0 : done_reg;
        len_cur   = msg_start ? '0 : len_reg;
        left_cur  = msg_start ? '0 : left_reg;
    end

    assign is_digit  = in_byte inside {[8'h30:8'h39]};
    assign is_blank  = in_byte inside {CH_SP, [8'h09:8'h0C]};
    assign digit_val = {{(LEN_BITS-4){1'b0}}, in_byte[3:0]};
    assign accum_x10 = {accum_cur[LEN_BITS-4:0], 3'b000} + {accum_cur[LEN_BITS-2:0], 1'b0};

    always_comb
    begin
        stage_next = stage_cur;
        pos_next   = pos_cur;
        match_next = match_cur;
        accum_next = accum_cur;
        done_next  = done_cur;
        len_next   = len_cur;
        left_next  = left_cur;

        result.valid          = 1'b0;
        result.kind           = KIND_METHOD;
        result.out_byte       = in_byte;
        result.body_len       = to_cl(len_cur);
        result.last_payload   = 1'b0;

        if (stage_cur == ST_PAYLOAD)
        begin
            result.valid        = 1'b1;
            result.kind         = KIND_PAYLOAD;
            result.last_payload = (left_cur == LEN_BITS'(1));
            left_next           = left_cur - LEN_BITS'(1);
            if (left_cur == LEN_BITS'(1))
            begin
                stage_next = ST_STOP;
            end
        end
        else if (in_byte == 8'h00)
        begin
            stage_next = ST_STOP;
        end
        else
        begin
            case (stage_cur)
                ST_FIRST:
                begin
                    if (!parse_mode)
                    begin
                        if (in_byte == CH_SP)
                        begin
                            stage_next = ST_PATH;
                        end
                        else
                        begin
                            result.valid = 1'b1;
                            result.kind  = KIND_METHOD;
                        end
                    end
                    else if (in_byte == CH_SP)
                    begin
                        stage_next = ST_STATUS;
                    end
                end
                ST_PATH:
                begin
                    if (in_byte == CH_QMARK)
                    begin
                        stage_next = ST_SKIPQ;
                    end
                    else
                    begin
                        result.valid = 1'b1;
                        result.kind  = KIND_PATH;
                    end
                end
                ST_SKIPQ:
                begin
                    if (in_byte == CH_EQ)
                    begin
                        stage_next = ST_QVAL;
                    end
                end
                ST_QVAL:
                begin
                    if (in_byte == CH_SP)
                    begin
                        stage_next = ST_EOL;
                    end
                    else
                    begin
                        result.valid = 1'b1;
                        result.kind  = KIND_QUERY;
                    end
                end
                ST_STATUS:
                begin
                    if (in_byte == CH_CR)
                    begin
                        stage_next = ST_EOL;
                    end
                    else
                    begin
                        result.valid = 1'b1;
                        result.kind  = KIND_QUERY;
                    end
                end
                ST_EOL:
                begin
                    if (in_byte == CH_LF)
                    begin
                        stage_next = ST_NAME;
                    end
                end
                ST_NAME:
                begin
                    if (in_byte == CH_CR)
                    begin
                        stage_next = ST_HDRCR;
                    end
                    else if (in_byte == CH_SP)
                    begin
                        stage_next = ST_VALUE;
                    end
                    else
                    begin
                        if (pos_cur >= 5'(NAME_LEN) || key_char(pos_cur[3:0]) != in_byte)
                        begin
                            match_next = 1'b0;
                        end
                        if (pos_cur != 5'd31)
                        begin
                            pos_next = pos_cur + 5'd1;
                        end
                    end
                end
                ST_VALUE:
                begin
                    if (in_byte == CH_CR)
                    begin
                        stage_next = ST_LINEEND;
                    end
                    else if (done_cur == 2'd0)
                    begin
                        if (is_digit)
                        begin
                            accum_next = digit_val;
                            done_next  = 2'd1;
                        end
                        else if (!is_blank)
                        begin
                            done_next = 2'd2;
                        end
                    end
                    else if (done_cur == 2'd1)
                    begin
                        if (is_digit)
                        begin
                            accum_next = accum_x10 + digit_val;
                        end
                        else
                        begin
                            done_next = 2'd2;
                        end
                    end
                end
                ST_LINEEND:
                begin
                    if (match_cur && pos_cur == 5'(NAME_LEN))
                    begin
                        len_next = accum_cur;
                    end
                    pos_next   = 5'd0;
                    match_next = 1'b1;
                    accum_next = '0;
                    done_next  = 2'd0;
                    stage_next = ST_NAME;
                end
                ST_HDRCR:
                begin
                    result.valid    = 1'b1;
                    result.kind     = KIND_HDR_DONE;
                    result.out_byte = 8'h00;
                    left_next       = len_cur;
                    stage_next      = (len_cur != '0) ? ST_PAYLOAD : ST_STOP;
                end
                default:
                begin
                    stage_next = ST_STOP;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= ST_FIRST;
            pos_reg   <= 5'd0;
            match_reg <= 1'b1;
            accum_reg <= '0;
            done_reg  <= 2'd0;
            len_reg   <= '0;
            left_reg  <= '0;
        end
        else if (step)
        begin
            stage_reg <= stage_next;
            pos_reg   <= pos_next;
            match_reg <= match_next;
            accum_reg <= accum_next;
            done_reg  <= done_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/hhfp_checker.sv @@
`default_nettype none

module hhfp_checker
    import hhfp_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic [2:0]  kind,
    input wire logic [7:0]  out_byte,
    input wire logic [31:0] body_len,
    input wire logic        last_payload
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(kind) && $stable(out_byte)
            && $stable(body_len) && $stable(last_payload))
        else $error("result changed while stalled");

    a_last_is_payload: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && last_payload |-> kind == KIND_PAYLOAD)
        else $error("last mark on a non-payload transaction");

    a_hdr_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind == KIND_HDR_DONE |-> out_byte == 8'h00 && !last_payload)
        else $error("headers-done transaction carries data");

    a_payload_needs_len: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind == KIND_PAYLOAD |-> body_len != 32'd0
            || LEN_BITS > CL_BITS)
        else $error("payload byte with zero announced length");

endmodule

bind http_header_field_parser_unit hhfp_checker u_hhfp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .kind           (res.kind),
    .out_byte       (res.out_byte),
    .body_len       (res.body_len),
    .last_payload   (res.last_payload)
);

`default_nettype wire
